### rtl/core/stq_pkg.sv
// Shared types and constants of the sorted timer queue.
package stq_pkg;

    localparam logic [15:0] ID_MAX = 16'hFFFF;

    // Command codes carried on s_tuser
    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_STOP    = 2'd1,
        CMD_RESCHED = 2'd2,
        CMD_PEEK    = 2'd3
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_EXHAUSTED = 2'd3
    } stat_t;

    // Read address source
    typedef enum logic [1:0] {
        RD_IDX  = 2'd0,
        RD_NEXT = 2'd1,
        RD_PREV = 2'd2,
        RD_HEAD = 2'd3
    } rd_sel_t;

    // Walk index update
    typedef enum logic [2:0] {
        IDX_HOLD  = 3'd0,
        IDX_ZERO  = 3'd1,
        IDX_INC   = 3'd2,
        IDX_DEC   = 3'd3,
        IDX_POS   = 3'd4,
        IDX_COUNT = 3'd5
    } idx_op_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DECIDE,
        S_REM_RD,
        S_REM_WR,
        S_REM_END,
        S_INS_PREP,
        S_INS_RD,
        S_INS_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INS_WR,
        S_HEAD_RD,
        S_DONE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    latch_in;
        logic    clr_scan;
        logic    scan_chk;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_shift;
        logic    wr_new;
        idx_op_t idx_op;
        logic    pos_from_idx;
        logic    ins_prep;
        logic    cnt_dec;
        logic    cnt_inc;
        logic    set_status;
        stat_t   status_code;
        logic    out_load;
    } stq_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        cmd_t cmd;
        logic count_zero;
        logic found;
        logic full;
        logic max_exh;
        logic scan_last;
        logic rem_last;
        logic idx_eq_count;
        logic idx_eq_pos;
        logic ins_stop;
        logic out_free;
    } stq_stat_t;

endpackage

### rtl/core/stq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### rtl/core/stq_ctrl.sv
// Controller state machine: sequences the scan, remove, insert and head read.
module stq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  stq_pkg::stq_stat_t st,
    output stq_pkg::stq_cmd_t  cmd
);
    import stq_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (st.cmd == CMD_PEEK) begin
                    state_next = S_HEAD_RD;
                end else if (st.count_zero) begin
                    state_next = S_DECIDE;
                end else begin
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: state_next = st.scan_last ? S_DECIDE : S_SCAN_RD;
            S_DECIDE: begin
                if (st.found) begin
                    state_next = S_REM_RD;
                end else if (st.cmd == CMD_START) begin
                    state_next = S_INS_PREP;
                end else begin
                    state_next = S_HEAD_RD;
                end
            end
            S_REM_RD:  state_next = st.rem_last ? S_REM_END : S_REM_WR;
            S_REM_WR:  state_next = S_REM_RD;
            S_REM_END: state_next = (st.cmd == CMD_STOP) ? S_HEAD_RD : S_INS_PREP;
            S_INS_PREP: begin
                if (st.cmd == CMD_START && (st.full || st.max_exh)) begin
                    state_next = S_HEAD_RD;
                end else begin
                    state_next = S_INS_RD;
                end
            end
            S_INS_RD:   state_next = st.idx_eq_count ? S_SHIFT_RD : S_INS_CHK;
            S_INS_CHK:  state_next = st.ins_stop ? S_SHIFT_RD : S_INS_RD;
            S_SHIFT_RD: state_next = st.idx_eq_pos ? S_INS_WR : S_SHIFT_WR;
            S_SHIFT_WR: state_next = S_SHIFT_RD;
            S_INS_WR:   state_next = S_HEAD_RD;
            S_HEAD_RD:  state_next = S_DONE;
            S_DONE: begin
                if (st.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        cmd             = '0;
        cmd.rd_sel      = RD_IDX;
        cmd.idx_op      = IDX_HOLD;
        cmd.status_code = STAT_OK;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    cmd.clr_scan = 1'b1;
                    cmd.idx_op   = IDX_ZERO;
                end
            end
            S_SCAN_RD: begin
                cmd.rd_en = 1'b1;
            end
            S_SCAN_CHK: begin
                cmd.scan_chk = 1'b1;
                cmd.idx_op   = st.scan_last ? IDX_HOLD : IDX_INC;
            end
            S_DECIDE: begin
                if (st.found) begin
                    cmd.idx_op = IDX_POS;
                end else if (st.cmd != CMD_START) begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STAT_NOT_FOUND;
                end
            end
            S_REM_RD: begin
                cmd.rd_en  = !st.rem_last;
                cmd.rd_sel = RD_NEXT;
            end
            S_REM_WR: begin
                cmd.wr_shift = 1'b1;
                cmd.idx_op   = IDX_INC;
            end
            S_REM_END: begin
                cmd.cnt_dec = 1'b1;
            end
            S_INS_PREP: begin
                if (st.cmd == CMD_START && st.full) begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STAT_FULL;
                end else if (st.cmd == CMD_START && st.max_exh) begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STAT_EXHAUSTED;
                end else begin
                    cmd.ins_prep = 1'b1;
                    cmd.idx_op   = IDX_ZERO;
                end
            end
            S_INS_RD: begin
                if (st.idx_eq_count) begin
                    cmd.pos_from_idx = 1'b1;
                end else begin
                    cmd.rd_en = 1'b1;
                end
            end
            S_INS_CHK: begin
                if (st.ins_stop) begin
                    cmd.pos_from_idx = 1'b1;
                    cmd.idx_op       = IDX_COUNT;
                end else begin
                    cmd.idx_op = IDX_INC;
                end
            end
            S_SHIFT_RD: begin
                cmd.rd_en  = !st.idx_eq_pos;
                cmd.rd_sel = RD_PREV;
            end
            S_SHIFT_WR: begin
                cmd.wr_shift = 1'b1;
                cmd.idx_op   = IDX_DEC;
            end
            S_INS_WR: begin
                cmd.wr_new  = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            S_HEAD_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_HEAD;
            end
            S_DONE: begin
                cmd.out_load = st.out_free;
            end
            default: ;
        endcase
    end
endmodule

### rtl/core/stq_dp.sv
// Datapath: entry memory, walk index, scan results and the result register.
module stq_dp #(
    parameter int DEPTH         = 16,
    parameter int ENDPOINT_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [95:0]        s_tdata,
    input  logic [1:0]         s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [87:0]        m_tdata,
    input  stq_pkg::stq_cmd_t  cmd,
    output stq_pkg::stq_stat_t st
);
    import stq_pkg::*;

    localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (ENDPOINT_BITS < 16) ? ENDPOINT_BITS : 16;
    // record layout: endpoint, period, deadline, id from the lowest bit up
    localparam int P_LO = EW;
    localparam int D_LO = EW + 31;
    localparam int I_LO = EW + 63;
    localparam int RW   = EW + 79;

    // captured beat
    cmd_t          cmd_reg;
    logic [31:0]   now_reg;
    logic [30:0]   period_reg;
    logic [EW-1:0] ep_reg;
    logic [15:0]   tid_reg;

    // walk and scan state
    logic [CW-1:0] count_reg, idx_reg, pos_reg;
    logic          found_reg;
    logic [15:0]   maxid_reg;
    logic [30:0]   sv_period_reg;
    logic [EW-1:0] sv_ep_reg;
    logic [RW-1:0] new_rec_reg;
    stat_t         status_reg;
    logic [15:0]   assigned_reg;
    logic          m_tvalid_reg;
    logic [87:0]   m_tdata_reg;

    // memory ports
    logic [RW-1:0] rdata;
    logic [AW-1:0] raddr, waddr;
    logic [RW-1:0] wdata;
    logic          we;

    logic [CW-1:0] idx_p1, idx_m1;
    logic [15:0]   rd_id;
    logic [31:0]   rd_deadline, diff;
    logic [30:0]   new_period;
    logic [15:0]   new_id;
    logic [EW-1:0] new_ep;
    logic [87:0]   out_word;

    assign idx_p1      = idx_reg + CW'(1);
    assign idx_m1      = idx_reg - CW'(1);
    assign rd_id       = rdata[RW-1:I_LO];
    assign rd_deadline = rdata[I_LO-1:D_LO];
    assign diff        = rd_deadline - new_rec_reg[I_LO-1:D_LO];

    // read address
    always_comb begin
        case (cmd.rd_sel)
            RD_IDX:  raddr = idx_reg[AW-1:0];
            RD_NEXT: raddr = idx_p1[AW-1:0];
            RD_PREV: raddr = idx_m1[AW-1:0];
            RD_HEAD: raddr = '0;
            default: raddr = '0;
        endcase
    end

    // write port: shifted entry at the index, or the new entry at its place
    assign we    = cmd.wr_shift | cmd.wr_new;
    assign waddr = cmd.wr_new ? pos_reg[AW-1:0] : idx_reg[AW-1:0];
    assign wdata = cmd.wr_new ? new_rec_reg : rdata;

    stq_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    // status to the controller
    always_comb begin
        st.cmd          = cmd_reg;
        st.count_zero   = (count_reg == '0);
        st.found        = found_reg;
        st.full         = (count_reg == CW'(DEPTH));
        st.max_exh      = (maxid_reg == ID_MAX);
        st.scan_last    = (idx_p1 == count_reg);
        st.rem_last     = (idx_p1 >= count_reg);
        st.idx_eq_count = (idx_reg == count_reg);
        st.idx_eq_pos   = (idx_reg == pos_reg);
        st.ins_stop     = (diff != 32'd0) && !diff[31];
        st.out_free     = !m_tvalid_reg || m_tready;
    end

    // fields of the entry being inserted
    assign new_period = (cmd_reg == CMD_START) ? period_reg : sv_period_reg;
    assign new_ep     = (cmd_reg == CMD_START) ? ep_reg : sv_ep_reg;
    assign new_id     = (cmd_reg == CMD_START) ? maxid_reg + 16'd1 : tid_reg;

    // result word: status, assigned id and the head read just before
    always_comb begin
        out_word       = '0;
        out_word[1:0]  = status_reg;
        out_word[17:2] = assigned_reg;
        if (count_reg != '0) begin
            out_word[18]    = 1'b1;
            out_word[34:19] = rd_id;
            out_word[50:35] = 16'(rdata[EW-1:0]);
            out_word[82:51] = rd_deadline;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.cnt_inc) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.cnt_dec) begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // walk, scan and payload registers
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            cmd_reg      <= cmd_t'(s_tuser);
            now_reg      <= s_tdata[31:0];
            period_reg   <= s_tdata[62:32];
            ep_reg       <= s_tdata[63 +: EW];
            tid_reg      <= s_tdata[94:79];
            status_reg   <= STAT_OK;
            assigned_reg <= 16'd0;
        end
        case (cmd.idx_op)
            IDX_ZERO:  idx_reg <= '0;
            IDX_INC:   idx_reg <= idx_p1;
            IDX_DEC:   idx_reg <= idx_m1;
            IDX_POS:   idx_reg <= pos_reg;
            IDX_COUNT: idx_reg <= count_reg;
            default:   idx_reg <= idx_reg;
        endcase
        if (cmd.clr_scan) begin
            found_reg <= 1'b0;
            maxid_reg <= 16'd0;
        end else if (cmd.scan_chk) begin
            // the matched entry is left out of the largest id
            if (rd_id == tid_reg && !found_reg) begin
                found_reg     <= 1'b1;
                pos_reg       <= idx_reg;
                sv_period_reg <= rdata[D_LO-1:P_LO];
                sv_ep_reg     <= rdata[EW-1:0];
            end else if (rd_id > maxid_reg) begin
                maxid_reg <= rd_id;
            end
        end
        if (cmd.pos_from_idx) begin
            pos_reg <= idx_reg;
        end
        if (cmd.set_status) begin
            status_reg <= cmd.status_code;
        end
        if (cmd.ins_prep) begin
            new_rec_reg <= {new_id, now_reg + {1'b0, new_period}, new_period, new_ep};
            if (cmd_reg == CMD_START) begin
                assigned_reg <= new_id;
            end
        end
        if (cmd.out_load) begin
            m_tdata_reg <= out_word;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH)) else $error("live count beyond depth");
    a_ins_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_inc |-> count_reg < CW'(DEPTH)) else $error("insert into full queue");
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready)) else $error("result overwritten");
    a_rem_found: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_dec |-> found_reg) else $error("removal without match");
endmodule

### rtl/core/sorted_timer_queue.sv
// Sorted timer queue: up to DEPTH timers ordered by wrapped deadline.
// One beat at a time. The result is loaded once the steps that the command needs are
// done (scan, removal of a match, insert search and shift, plus decide, prepare and
// head read), later while an earlier result is pending and m_tready is low; a peek
// skips the scan and goes to the head read. The next beat is taken the cycle after the load.
// Synchronous active-low reset empties the queue; entries are not cleared.
module sorted_timer_queue #(
    parameter int DEPTH         = 16,
    parameter int ENDPOINT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // now_ms[31:0], period_ms[62:32], endpoint[78:63], timer_id[94:79], zero pad
    input  logic [95:0] s_tdata,
    // command[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], assigned_id[17:2], head_valid[18], head_id[34:19],
    // head_endpoint[50:35], head_deadline[82:51], zero pad
    output logic [87:0] m_tdata
);
    import stq_pkg::*;

    stq_cmd_t  cmd;
    stq_stat_t st;

    stq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    stq_dp #(.DEPTH(DEPTH), .ENDPOINT_BITS(ENDPOINT_BITS)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .st       (st)
    );
endmodule
